// ===== hdl/md5sh_pkg.sv =====
// Shared types, constants and round tables for the streaming MD5 hasher.
package md5sh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_PAD2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic byte_wr;
    logic pad_wr;
    logic pad_marker;
    logic pad_len;
    logic load;
    logic round;
    logic fold;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pad_fits;
    logic round_last;
  } status_t;

  localparam logic [3:0][31:0] INIT_WORDS = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] r;
    logic [3:0] g;
    r = i[3:0];
    case (i[5:4])
      2'd0: g = r;
      2'd1: g = 4'(r * 4'd5 + 4'd1);
      2'd2: g = 4'(r * 4'd3 + 4'd5);
      2'd3: g = 4'(r * 4'd7);
      default: g = r;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] sel, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (sel)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = 32'h0;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

endpackage

// ===== hdl/md5sh_dp.sv =====
// Datapath: chaining words, block buffer, byte counter, padding and the round unit.
module md5sh_dp (
  input  logic              clk,
  input  logic              rst,
  input  md5sh_pkg::cmd_t    cmd,
  input  logic [7:0]        data_byte,
  output md5sh_pkg::status_t sts,
  output logic [3:0][31:0]  chain_out
);
  import md5sh_pkg::*;

  logic [3:0][31:0] chain;
  logic [31:0]      blk [16];
  logic [60:0]      byte_count;
  logic [31:0]      wa, wb, wc, wd;
  logic [31:0]      km;
  logic [5:0]       round_index;

  logic [5:0]       pos;
  logic [63:0]      bit_len;
  logic [31:0]      pad_word [16];
  logic [31:0]      b_next;
  logic [5:0]       km_idx;
  logic [31:0]      km_next;

  assign pos     = byte_count[5:0];
  assign bit_len = {byte_count, 3'b000};

  assign sts.pos_last   = (pos == 6'd63);
  assign sts.pad_fits   = (pos < 6'd56);
  assign sts.round_last = (round_index == 6'd63);

  assign chain_out = chain;

  assign b_next = wb + rotl32(wa + round_f(round_index[5:4], wb, wc, wd) + km,
                              rot_amt(round_index));

  assign km_idx  = cmd.load ? 6'd0 : round_index + 6'd1;
  assign km_next = sine_k(km_idx) + blk[msg_idx(km_idx)];

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      if (!cmd.pad_marker) begin
        pad_word[j] = 32'h0;
      end else if (4'(j) < pos[5:2]) begin
        pad_word[j] = blk[j];
      end else if (4'(j) == pos[5:2]) begin
        case (pos[1:0])
          2'd0: pad_word[j] = {24'h0, PAD_BYTE};
          2'd1: pad_word[j] = {16'h0, PAD_BYTE, blk[j][7:0]};
          2'd2: pad_word[j] = {8'h0, PAD_BYTE, blk[j][15:0]};
          2'd3: pad_word[j] = {PAD_BYTE, blk[j][23:0]};
          default: pad_word[j] = 32'h0;
        endcase
      end else begin
        pad_word[j] = 32'h0;
      end
      if (cmd.pad_len && j == 14) begin
        pad_word[j] = bit_len[31:0];
      end
      if (cmd.pad_len && j == 15) begin
        pad_word[j] = bit_len[63:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain       <= INIT_WORDS;
      byte_count  <= '0;
      round_index <= '0;
    end else begin
      if (cmd.fold) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
      end
      if (cmd.capture) begin
        chain      <= INIT_WORDS;
        byte_count <= '0;
      end
      if (cmd.byte_wr) begin
        byte_count <= byte_count + 61'd1;
      end
      if (cmd.load) begin
        round_index <= '0;
      end else if (cmd.round) begin
        round_index <= round_index + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      km <= km_next;
    end else if (cmd.round) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= b_next;
      km <= km_next;
    end
    if (cmd.byte_wr) begin
      blk[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= data_byte;
    end else if (cmd.pad_wr) begin
      for (int j = 0; j < 16; j++) begin
        blk[j] <= pad_word[j];
      end
    end
  end

endmodule

// ===== hdl/md5sh_out.sv =====
// Digest output register: holds the four result words and sends them one per transaction.
module md5sh_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [3:0][31:0] words_in,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      digest_word,
  output logic [1:0]       word_index,
  output logic             last_word
);

  logic [3:0][31:0] words;
  logic             valid;
  logic [1:0]       idx;

  assign busy        = valid;
  assign out_valid   = valid;
  assign digest_word = words[idx];
  assign word_index  = idx;
  assign last_word   = (idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (valid && out_ready) begin
      idx <= idx + 2'd1;
      if (idx == 2'd3) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words <= words_in;
    end
  end

endmodule

// ===== hdl/md5sh_ctrl.sv =====
// Controller: sequences byte intake, padding, the 64 rounds and digest hand-off.
module md5sh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              has_byte,
  input  logic              msg_end,
  output logic              in_ready,
  input  md5sh_pkg::status_t sts,
  input  logic              out_busy,
  output md5sh_pkg::cmd_t    cmd
);
  import md5sh_pkg::*;

  state_t state, state_next;
  logic   end_pend, end_pend_next;
  logic   pad_extra, pad_extra_next;
  logic   last_blk, last_blk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      end_pend  <= 1'b0;
      pad_extra <= 1'b0;
      last_blk  <= 1'b0;
    end else begin
      state     <= state_next;
      end_pend  <= end_pend_next;
      pad_extra <= pad_extra_next;
      last_blk  <= last_blk_next;
    end
  end

  always_comb begin
    state_next     = state;
    end_pend_next  = end_pend;
    pad_extra_next = pad_extra;
    last_blk_next  = last_blk;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (has_byte) begin
            cmd.byte_wr = 1'b1;
            if (sts.pos_last) begin
              state_next    = ST_LOAD;
              end_pend_next = msg_end;
            end else if (msg_end) begin
              state_next = ST_PAD;
            end
          end else if (msg_end) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.pad_wr     = 1'b1;
        cmd.pad_marker = 1'b1;
        cmd.pad_len    = sts.pad_fits;
        last_blk_next  = sts.pad_fits;
        pad_extra_next = !sts.pad_fits;
        end_pend_next  = 1'b0;
        state_next     = ST_LOAD;
      end
      ST_PAD2: begin
        cmd.pad_wr     = 1'b1;
        cmd.pad_len    = 1'b1;
        pad_extra_next = 1'b0;
        last_blk_next  = 1'b1;
        state_next     = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (end_pend) begin
          state_next = ST_PAD;
        end else if (pad_extra) begin
          state_next = ST_PAD2;
        end else if (last_blk) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          cmd.capture   = 1'b1;
          last_blk_next = 1'b0;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !out_busy)
    else $error("digest captured while output register still busy");

  a_fold_after_rounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_FOLD |-> $past(state) == ST_ROUND && $past(sts.round_last))
    else $error("fold without a full round sequence");

  a_len_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.pad_wr && cmd.pad_len |-> !cmd.pad_marker || sts.pad_fits)
    else $error("length written over marker block that has no room");

endmodule

// ===== hdl/md5_stream_hash.sv =====
// Streaming MD5 hasher top level: byte transactions in, four digest word transactions out.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  input   | in_valid / in_ready  | data_byte, has_byte, msg_end
//  output  | out_valid / out_ready| digest_word, word_index, last_word
//
// A byte transaction is written into the block buffer; one that fills a 64-byte block also
// starts a load, 64 rounds of the single round unit and a fold into the chaining words.
// A message end adds a pad step and one more such pass, twice when the length does not fit,
// then hands the digest to the free output register, which drains one word per ready cycle.
// Input is taken again once the digest is handed off, while words still drain.
// Synchronous reset, no clearing pass; output stalls hold the digest in place.
module md5_stream_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        msg_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);
  import md5sh_pkg::*;

  cmd_t             cmd;
  status_t          sts;
  logic             out_busy;
  logic [3:0][31:0] chain;

  md5sh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .has_byte (has_byte),
    .msg_end  (msg_end),
    .in_ready (in_ready),
    .sts      (sts),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  md5sh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (data_byte),
    .sts       (sts),
    .chain_out (chain)
  );

  md5sh_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (cmd.capture),
    .words_in    (chain),
    .busy        (out_busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule
